### hdl/owaf_pkg.sv
package owaf_pkg;

	localparam int IN_W       = 15;
	localparam int OUT_W      = 16;
	localparam int K_W        = 21;
	localparam int Q_W        = 20;
	localparam int PI_Q12     = 12868;
	localparam int TWO_PI_Q12 = 25736;
	localparam int DEG_K_Q20  = 1877468;
	localparam int OUT_LIMIT  = 23040;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_YAW_ADD,
		ST_YAW_WRAP,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic yaw_add;
		logic yaw_wrap;
		logic mul;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic acc_last;
	} sts_t;

endpackage

### hdl/owaf_ctrl.sv
module owaf_ctrl
	import owaf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  logic m_tready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (sts.acc_last) begin
					state_d = ST_YAW_ADD;
				end
			end
			ST_YAW_ADD:  state_d = ST_YAW_WRAP;
			ST_YAW_WRAP: state_d = ST_MUL;
			ST_MUL:      state_d = ST_DIV;
			ST_DIV:      state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_ACC:      cmd.step     = 1'b1;
			ST_YAW_ADD:  cmd.yaw_add  = 1'b1;
			ST_YAW_WRAP: cmd.yaw_wrap = 1'b1;
			ST_MUL:      cmd.mul      = 1'b1;
			ST_DIV:      cmd.div_step = 1'b1;
			ST_DONE:     cmd.out_load = out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

### hdl/owaf_datapath.sv
module owaf_datapath
	import owaf_pkg::*;
#(
	parameter int WINDOW_LEN = 15
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [IN_W-1:0]  in_pitch,
	input  logic signed [IN_W-1:0]  in_roll,
	input  logic signed [IN_W-1:0]  in_yaw,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	output logic signed [OUT_W-1:0] out_pitch,
	output logic signed [OUT_W-1:0] out_roll,
	output logic signed [OUT_W-1:0] out_yaw
);

	localparam int T      = WINDOW_LEN * (WINDOW_LEN + 1) / 2;
	localparam int TW     = $clog2(T + 1);
	localparam int WT_W   = $clog2(WINDOW_LEN + 1);
	localparam int D_W    = IN_W + 2;
	localparam int ACC_W  = 19 + TW;
	localparam int PROD_W = ACC_W + K_W;
	localparam int MP_W   = D_W + WT_W + 1;
	localparam int OT_W   = IN_W + TW + 1;
	localparam int L_T    = $clog2(T);
	localparam int X_W    = 17 + L_T;
	localparam int R_W    = X_W + 1;
	localparam int SH     = X_W + L_T;
	localparam int QP_W   = X_W + R_W;

	localparam longint RECIP = ((longint'(1) << SH) + longint'(T) - 1) / longint'(T);

	localparam logic [TW-1:0]           T_U        = TW'(T);
	localparam logic signed [ACC_W-1:0] PI_T       = ACC_W'(PI_Q12 * T);
	localparam logic signed [ACC_W-1:0] TWO_PI_T   = ACC_W'(TWO_PI_Q12 * T);
	localparam logic [PROD_W:0]         ROUND_HALF = (PROD_W + 1)'(T) << 19;
	localparam logic signed [D_W-1:0]   PI_D       = D_W'(PI_Q12);
	localparam logic signed [D_W-1:0]   TWO_PI_D   = D_W'(TWO_PI_Q12);
	localparam logic [R_W-1:0]          RECIP_R    = R_W'(RECIP);

	logic signed [IN_W-1:0]  win_q [3][WINDOW_LEN];
	logic signed [IN_W-1:0]  in_v  [3];
	logic signed [IN_W-1:0]  off_q;
	logic [WT_W-1:0]         wt_q;
	logic signed [ACC_W-1:0] acc_q [3];
	logic [X_W-1:0]          num_q [3];
	logic [Q_W-1:0]          quo_q [3];
	logic                    neg_q [3];
	logic signed [OUT_W-1:0] res_q [3];

	logic signed [D_W-1:0]   dy_raw;
	logic signed [D_W-1:0]   dy;
	logic signed [D_W-1:0]   tap   [3];
	logic signed [MP_W-1:0]  mprod [3];
	logic signed [OT_W-1:0]  off_t;
	logic [ACC_W-1:0]        mag   [3];
	logic [PROD_W:0]         scl   [3];
	logic [QP_W-1:0]         qprod [3];
	logic [Q_W-1:0]          qsat  [3];
	logic signed [OUT_W-1:0] res_d [3];

	assign in_v[0] = in_pitch;
	assign in_v[1] = in_roll;
	assign in_v[2] = in_yaw;

	always_comb begin
		dy_raw = D_W'(win_q[2][0]) - D_W'(off_q);
		if (dy_raw > PI_D) begin
			dy = dy_raw - TWO_PI_D;
		end else if (dy_raw < -PI_D) begin
			dy = dy_raw + TWO_PI_D;
		end else begin
			dy = dy_raw;
		end
		tap[0] = D_W'(win_q[0][0]);
		tap[1] = D_W'(win_q[1][0]);
		tap[2] = dy;
		off_t  = off_q * $signed({1'b0, T_U});
		for (int c = 0; c < 3; c++) begin
			mprod[c] = tap[c] * $signed({1'b0, wt_q});
			mag[c]   = acc_q[c][ACC_W-1] ? ACC_W'(-acc_q[c]) : ACC_W'(acc_q[c]);
			scl[c]   = (PROD_W + 1)'(mag[c] * K_W'(DEG_K_Q20)) + ROUND_HALF;
			qprod[c] = num_q[c] * RECIP_R;
			qsat[c]  = (quo_q[c] > Q_W'(OUT_LIMIT)) ? Q_W'(OUT_LIMIT) : quo_q[c];
			res_d[c] = neg_q[c] ? -OUT_W'(qsat[c]) : OUT_W'(qsat[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				for (int i = 0; i < WINDOW_LEN; i++) begin
					win_q[c][i] <= '0;
				end
			end
		end else if (cmd.load || cmd.step) begin
			for (int c = 0; c < 3; c++) begin
				for (int i = 0; i < WINDOW_LEN - 1; i++) begin
					win_q[c][i] <= win_q[c][i + 1];
				end
				win_q[c][WINDOW_LEN - 1] <= cmd.load ? in_v[c] : win_q[c][0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			off_q <= in_yaw;
			wt_q  <= WT_W'(1);
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= '0;
			end
		end
		if (cmd.step) begin
			wt_q <= wt_q + WT_W'(1);
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= acc_q[c] + ACC_W'(mprod[c]);
			end
		end
		if (cmd.yaw_add) begin
			acc_q[2] <= acc_q[2] + ACC_W'(off_t);
		end
		if (cmd.yaw_wrap) begin
			if (acc_q[2] > PI_T) begin
				acc_q[2] <= acc_q[2] - TWO_PI_T;
			end else if (acc_q[2] < -PI_T) begin
				acc_q[2] <= acc_q[2] + TWO_PI_T;
			end
		end
		if (cmd.mul) begin
			for (int c = 0; c < 3; c++) begin
				num_q[c] <= X_W'(scl[c] >> 20);
				neg_q[c] <= acc_q[c][ACC_W-1];
			end
		end
		if (cmd.div_step) begin
			for (int c = 0; c < 3; c++) begin
				quo_q[c] <= Q_W'(qprod[c] >> SH);
			end
		end
		if (cmd.out_load) begin
			for (int c = 0; c < 3; c++) begin
				res_q[c] <= res_d[c];
			end
		end
	end

	assign sts.acc_last = (wt_q == WT_W'(WINDOW_LEN));

	assign out_pitch = res_q[0];
	assign out_roll  = res_q[1];
	assign out_yaw   = res_q[2];

endmodule

### hdl/orientation_weighted_average_filter.sv
// Channel  Dir  Width  Contents
// s_axis   in   48     one orientation sample, radians Q3.12
// m_axis   out  48     one filtered orientation, degrees Q9.7
//
// From accept to the next accept, one tap of the history windows is multiplied
// and accumulated per cycle, then come the heading offset, the heading wrap,
// the degree scaling, the reciprocal multiply that divides by the weight total,
// the output load and the accept, one state each; the output load waits while
// an earlier result in the output register has not been taken.
// arst_n clears the history windows to zero and empties the output register.
// A result waiting in the output register holds; the next sample is accepted
// meanwhile and its result waits until the pending beat is taken.
module orientation_weighted_average_filter
	import owaf_pkg::*;
#(
	parameter int WINDOW_LEN = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // pitch_rad[14:0], roll_rad[29:15], yaw_rad[44:30], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // pitch_deg[15:0], roll_deg[31:16], yaw_deg[47:32]
);

	cmd_t                    cmd;
	sts_t                    sts;
	logic signed [OUT_W-1:0] pitch_deg;
	logic signed [OUT_W-1:0] roll_deg;
	logic signed [OUT_W-1:0] yaw_deg;

	owaf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	owaf_datapath #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_pitch  ($signed(s_tdata[14:0])),
		.in_roll   ($signed(s_tdata[29:15])),
		.in_yaw    ($signed(s_tdata[44:30])),
		.cmd       (cmd),
		.sts       (sts),
		.out_pitch (pitch_deg),
		.out_roll  (roll_deg),
		.out_yaw   (yaw_deg)
	);

	assign m_tdata = {yaw_deg, roll_deg, pitch_deg};

endmodule

### tb/orientation_weighted_average_filter_test.sv
module orientation_weighted_average_filter_test;
	timeunit 1ns;
	timeprecision 1ps;
	import owaf_pkg::*;

	localparam int TAPS           = 15;
	localparam int WEIGHT_SUM     = TAPS * (TAPS + 1) / 2;
	localparam int LATENCY        = TAPS + 6;
	localparam int CLK_PERIOD     = 12;
	localparam int TIMEOUT_CYCLES = 600000;

	localparam int IN_MAX = 2 ** (IN_W - 1) - 1;
	localparam int IN_MIN = -(2 ** (IN_W - 1));

	typedef struct {
		logic signed [OUT_W-1:0] pitch_deg;
		logic signed [OUT_W-1:0] roll_deg;
		logic signed [OUT_W-1:0] yaw_deg;
	} orient_deg_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;

	logic signed [IN_W-1:0] pitch_hist [TAPS];
	logic signed [IN_W-1:0] roll_hist  [TAPS];
	logic signed [IN_W-1:0] yaw_hist   [TAPS];
	orient_deg_t            filtered_q [$];
	orient_deg_t            want;

	int fail_count;
	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold;
	int traj_pitch;
	int traj_roll;
	int traj_yaw;
	int yaw_rate;
	int seg_left;

	orientation_weighted_average_filter #(
		.WINDOW_LEN(TAPS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("orientation_weighted_average_filter regression: fail");
		$finish;
	end

	function automatic logic signed [OUT_W-1:0] deg_from_sum(input longint sum);
		longint num;
		longint den;
		longint mag;
		longint q;
		num = sum * DEG_K_Q20;
		den = longint'(WEIGHT_SUM) << Q_W;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		if (q > OUT_LIMIT)
			q = OUT_LIMIT;
		return OUT_W'((num < 0) ? -q : q);
	endfunction

	function automatic void predict_filtered(input logic signed [IN_W-1:0] p, r, y);
		longint      sp;
		longint      sr;
		longint      sy;
		longint      d;
		longint      newest;
		orient_deg_t res;
		sp = 0;
		sr = 0;
		sy = 0;
		for (int i = 0; i < TAPS - 1; i++) begin
			pitch_hist[i] = pitch_hist[i + 1];
			roll_hist[i]  = roll_hist[i + 1];
			yaw_hist[i]   = yaw_hist[i + 1];
		end
		pitch_hist[TAPS - 1] = p;
		roll_hist[TAPS - 1]  = r;
		yaw_hist[TAPS - 1]   = y;
		newest = longint'(yaw_hist[TAPS - 1]);
		for (int i = 0; i < TAPS; i++) begin
			d = longint'(yaw_hist[i]) - newest;
			if (d > PI_Q12)
				d -= TWO_PI_Q12;
			else if (d < -PI_Q12)
				d += TWO_PI_Q12;
			sp += longint'(pitch_hist[i]) * (i + 1);
			sr += longint'(roll_hist[i]) * (i + 1);
			sy += d * (i + 1);
		end
		sy += newest * WEIGHT_SUM;
		if (sy > longint'(PI_Q12) * WEIGHT_SUM)
			sy -= longint'(TWO_PI_Q12) * WEIGHT_SUM;
		else if (sy < -longint'(PI_Q12) * WEIGHT_SUM)
			sy += longint'(TWO_PI_Q12) * WEIGHT_SUM;
		res.pitch_deg = deg_from_sum(sp);
		res.roll_deg  = deg_from_sum(sr);
		res.yaw_deg   = deg_from_sum(sy);
		filtered_q.push_back(res);
	endfunction

	function automatic void check_field(input string name,
			input logic signed [OUT_W-1:0] expd, act);
		if (act !== expd) begin
			$error("%s: expected %0d, got %0d", name, expd, act);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (filtered_q.size() == 0) begin
				$error("result beat %h with nothing expected", m_tdata);
				fail_count++;
			end else begin
				want = filtered_q.pop_front();
				check_field("pitch_deg", want.pitch_deg, m_tdata[15:0]);
				check_field("roll_deg", want.roll_deg, m_tdata[31:16]);
				check_field("yaw_deg", want.yaw_deg, m_tdata[47:32]);
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				rx_hold--;
			end else
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_sample(input int p, r, y);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, IN_W'(y), IN_W'(r), IN_W'(p)};
		do @(posedge clk); while (!s_tready);
		predict_filtered(IN_W'(p), IN_W'(r), IN_W'(y));
		@(negedge clk);
	endtask

	function automatic int rand_between(input int lo, hi);
		return lo + int'($urandom_range(hi - lo));
	endfunction

	function automatic int clamp_pi(input int v);
		if (v > PI_Q12)
			return PI_Q12;
		if (v < -PI_Q12)
			return -PI_Q12;
		return v;
	endfunction

	task automatic random_sample(output int p, r, y);
		int kind;
		kind = $urandom_range(99);
		if (kind < 60) begin
			if (seg_left == 0) begin
				yaw_rate = rand_between(-1500, 1500);
				seg_left = $urandom_range(40, 5);
			end
			seg_left--;
			traj_pitch = clamp_pi(traj_pitch + rand_between(-300, 300));
			traj_roll  = clamp_pi(traj_roll + rand_between(-300, 300));
			traj_yaw   = traj_yaw + yaw_rate + rand_between(-100, 100);
			if (traj_yaw > PI_Q12)
				traj_yaw -= TWO_PI_Q12;
			else if (traj_yaw < -PI_Q12)
				traj_yaw += TWO_PI_Q12;
			p = traj_pitch;
			r = traj_roll;
			y = traj_yaw;
		end else if (kind < 90) begin
			p = rand_between(-PI_Q12, PI_Q12);
			r = rand_between(-PI_Q12, PI_Q12);
			y = rand_between(-PI_Q12, PI_Q12);
		end else begin
			p = $urandom;
			r = $urandom;
			y = $urandom;
		end
	endtask

	task automatic run_random(input int count);
		int p, r, y;
		repeat (count) begin
			random_sample(p, r, y);
			send_sample(p, r, y);
		end
	endtask

	task automatic test_extremes();
		send_sample(0, 0, 0);
		for (int i = 0; i < 10; i++)
			send_sample(IN_MAX, IN_MIN, (i % 2) ? IN_MAX : IN_MIN);
		for (int i = 0; i < 6; i++)
			send_sample(IN_MIN, IN_MAX, (i % 2) ? IN_MIN : IN_MAX);
	endtask

	task automatic test_heading_wrap();
		send_sample(0, 0, PI_Q12);
		send_sample(0, 0, -PI_Q12);
		send_sample(100, -100, 12000);
		send_sample(-100, 100, -12500);
		send_sample(PI_Q12, -PI_Q12, PI_Q12 / 2);
		send_sample(-PI_Q12, PI_Q12, -PI_Q12 / 2);
		send_sample(PI_Q12 / 4, -PI_Q12 / 4, PI_Q12 - 1);
		send_sample(-PI_Q12 / 4, PI_Q12 / 4, -PI_Q12 + 1);
	endtask

	task automatic test_no_idling();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		run_random(450);
	endtask

	task automatic test_sender_idle();
		tx_idle_pct  = 79;
		rx_stall_pct = 0;
		run_random(350);
	endtask

	task automatic test_receiver_stall();
		tx_idle_pct  = 0;
		rx_stall_pct = 79;
		run_random(350);
	endtask

	task automatic test_both_idle();
		tx_idle_pct  = 18;
		rx_stall_pct = 18;
		run_random(350);
	endtask

	task automatic test_backpressure();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold      = 40 * LATENCY;
		run_random(50);
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		fail_count   = 0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold      = 0;
		traj_pitch   = 0;
		traj_roll    = 0;
		traj_yaw     = 0;
		yaw_rate     = 0;
		seg_left     = 0;
		for (int i = 0; i < TAPS; i++) begin
			pitch_hist[i] = '0;
			roll_hist[i]  = '0;
			yaw_hist[i]   = '0;
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		test_heading_wrap();
		test_no_idling();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();

		s_tvalid <= 1'b0;
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("orientation_weighted_average_filter regression: pass");
		else
			$display("orientation_weighted_average_filter regression: fail");
		$finish;
	end

endmodule

### orientation_weighted_average_filter.f
hdl/owaf_pkg.sv
hdl/owaf_ctrl.sv
hdl/owaf_datapath.sv
hdl/orientation_weighted_average_filter.sv
tb/orientation_weighted_average_filter_test.sv
